// ----- sv/scba_pkg.sv -----
package scba_pkg;

  // fixed field widths
  localparam int unsigned REQ_W    = 32;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CLS_W    = 4;
  localparam int unsigned LIMIT_W  = 17;

  // parameter defaults
  localparam int unsigned DEF_ARENA_BYTES  = 65536;
  localparam int unsigned DEF_HEADER_BYTES = 8;
  localparam int unsigned DEF_CLASS_COUNT  = 10;

  // arena limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LARGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  // tag layout: class in low bits, live bit, then free list link
  localparam logic [CLS_W-1:0] TAG_CLASS_NONE = 4'hF;
  localparam int unsigned      TAG_LIVE_BIT   = 4;
  localparam int unsigned      TAG_LINK_LSB   = 5;

  // largest user address
  localparam logic [31:0] USER_ADDR_MAX = 32'h0000_FFFF;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // request accepted, capture and read memory
    logic in_exec;  // execute phase in progress
    logic fire;     // execute phase completes, commit and load result
    logic clear;    // tag clearing pass
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

// ----- sv/scba_if.sv -----
interface scba_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [scba_pkg::REQ_W-1:0]      req_size;
  logic [scba_pkg::ADDR_W-1:0]     free_addr;

  modport source (output valid, output action, output req_size, output free_addr,
                  input ready);
  modport sink   (input valid, input action, input req_size, input free_addr,
                  output ready);
endinterface

interface scba_out_if;
  logic                            valid;
  logic                            ready;
  logic [scba_pkg::STATUS_W-1:0]   status;
  logic [scba_pkg::ADDR_W-1:0]     user_addr;
  logic [scba_pkg::CLS_W-1:0]      size_class;

  modport source (output valid, output status, output user_addr, output size_class,
                  input ready);
  modport sink   (input valid, input status, input user_addr, input size_class,
                  output ready);
endinterface

// ----- sv/scba_ctrl.sv -----
module scba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  scba_pkg::sts_t  sts,
  output scba_pkg::cmd_t  cmd
);
  import scba_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       fire;

  // handshake decode
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // commands
  assign cmd.load    = accept;
  assign cmd.in_exec = (state_r == S_EXEC);
  assign cmd.fire    = fire;
  assign cmd.clear   = (state_r == S_CLEAR);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/scba_datapath.sv -----
module scba_datapath #(
  parameter int unsigned ARENA_BYTES  = scba_pkg::DEF_ARENA_BYTES,
  parameter int unsigned HEADER_BYTES = scba_pkg::DEF_HEADER_BYTES,
  parameter int unsigned CLASS_COUNT  = scba_pkg::DEF_CLASS_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  scba_pkg::cmd_t                    cmd,
  output scba_pkg::sts_t                    sts,
  input  logic                              in_action,
  input  logic [scba_pkg::REQ_W-1:0]        in_req_size,
  input  logic [scba_pkg::ADDR_W-1:0]       in_free_addr,
  input  logic                              cfg_wr_en,
  input  logic [scba_pkg::LIMIT_W-1:0]      cfg_wr_data,
  output logic [scba_pkg::STATUS_W-1:0]     out_status,
  output logic [scba_pkg::ADDR_W-1:0]       out_user_addr,
  output logic [scba_pkg::CLS_W-1:0]        out_size_class
);
  import scba_pkg::*;

  localparam int unsigned GRANULES = ARENA_BYTES / 8;
  localparam int unsigned GW       = $clog2(GRANULES);
  localparam int unsigned LW       = $clog2(GRANULES + 1);
  localparam int unsigned TW       = LW + TAG_LINK_LSB;
  localparam int unsigned BW       = $clog2(ARENA_BYTES + 1);
  localparam int unsigned HIW      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam logic [31:0] ARENA32  = 32'(ARENA_BYTES);
  localparam logic [31:0] HDR32    = 32'(HEADER_BYTES);
  localparam logic [31:0] CLS32    = 32'(CLASS_COUNT);
  localparam logic [TW-1:0] TAG_RESET = {{LW{1'b0}}, 1'b0, TAG_CLASS_NONE};

  // tag memory, one word per 8-byte granule
  logic [TW-1:0] tag_mem [GRANULES];
  logic [TW-1:0] rd_r;
  logic          mem_we;
  logic [GW-1:0] waddr;
  logic [TW-1:0] wdata;
  logic [GW-1:0] raddr;

  // control state
  logic [LW-1:0]      head_r   [CLASS_COUNT];
  logic [LW-1:0]      head_nxt [CLASS_COUNT];
  logic [BW-1:0]      bump_r, bump_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [GW-1:0]      clr_cnt_r;

  // captured request
  logic             act_r;
  logic [CLS_W-1:0] cls_r;
  logic [LW-1:0]    head_q_r;
  logic [GW-1:0]    gran_r;
  logic             bad_r;

  // result registers
  logic [STATUS_W-1:0] status_r;
  logic [ADDR_W-1:0]   user_addr_r;
  logic [CLS_W-1:0]    size_class_r;

  // request decode
  logic [32:0]      total;
  logic [CLS_W-1:0] cls_in;
  logic [31:0]      blk_in;
  logic             free_bad;
  logic [GW-1:0]    free_gran;
  logic [CLS_W-1:0] hsel;
  logic [LW-1:0]    head_rd;

  // execute phase
  logic                too_large;
  logic                pop;
  logic [GW-1:0]       pop_g;
  logic [31:0]         lim32;
  logic [31:0]         size32;
  logic [31:0]         bump32;
  logic [31:0]         blk32;
  logic [31:0]         ua_sum;
  logic                nospace;
  logic [CLS_W-1:0]    f_cls;
  logic                f_ok;
  logic [STATUS_W-1:0] ex_status;
  logic [ADDR_W-1:0]   ex_addr;
  logic [CLS_W-1:0]    ex_cls;
  logic                ex_we;
  logic [GW-1:0]       ex_waddr;
  logic [TW-1:0]       ex_wdata;
  logic                head_we;
  logic [CLS_W-1:0]    head_wi;
  logic [LW-1:0]       head_wv;
  logic                bump_we;

  // size class: smallest power of two class that holds size plus header
  assign total = {1'b0, in_req_size} + 33'(HEADER_BYTES);
  always_comb begin
    cls_in = CLS_W'(CLASS_COUNT);
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (total <= (33'd8 << c)) cls_in = CLS_W'(c);
    end
  end

  // free address checks
  assign blk_in    = 32'(in_free_addr) - HDR32;
  assign free_bad  = (in_free_addr == '0) || (32'(in_free_addr) < HDR32) ||
                     (blk_in[2:0] != 3'd0) || (blk_in >= ARENA32);
  assign free_gran = blk_in[GW+2:3];

  // single list head read port: request class on accept, tag class in execute
  assign hsel    = cmd.in_exec ? rd_r[CLS_W-1:0] : cls_in;
  assign head_rd = (32'(hsel) < CLS32) ? head_r[HIW'(hsel)] : '0;

  // tag read address: freed granule or head of the list to pop
  assign raddr = (in_action == ACT_FREE) ? free_gran : GW'(head_rd - LW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r     <= tag_mem[raddr];
      act_r    <= in_action;
      cls_r    <= cls_in;
      head_q_r <= head_rd;
      gran_r   <= free_gran;
      bad_r    <= free_bad;
    end
  end

  // allocate path
  assign too_large = (32'(cls_r) >= CLS32);
  assign pop       = (head_q_r != '0);
  assign pop_g     = GW'(head_q_r - LW'(1));
  assign lim32     = (32'(limit_r) < ARENA32) ? 32'(limit_r) : ARENA32;
  assign size32    = 32'd8 << cls_r;
  assign bump32    = 32'(bump_r);
  assign blk32     = pop ? (32'(pop_g) << 3) : bump32;
  assign ua_sum    = blk32 + HDR32;
  assign nospace   = (ua_sum > USER_ADDR_MAX) || (!pop && (bump32 + size32 > lim32));

  // free path
  assign f_cls = rd_r[CLS_W-1:0];
  assign f_ok  = !bad_r && rd_r[TAG_LIVE_BIT] && (32'(f_cls) < CLS32);

  // execute decision
  always_comb begin
    ex_status = ST_IGNORED;
    ex_addr   = '0;
    ex_cls    = '0;
    ex_we     = 1'b0;
    ex_waddr  = gran_r;
    ex_wdata  = TAG_RESET;
    head_we   = 1'b0;
    head_wi   = cls_r;
    head_wv   = '0;
    bump_we   = 1'b0;
    bump_nxt  = BW'(bump32 + size32);
    if (act_r == ACT_ALLOC) begin
      if (too_large) begin
        ex_status = ST_LARGE;
        ex_cls    = CLS_W'(CLASS_COUNT);
      end else if (nospace) begin
        ex_status = ST_NOSPACE;
        ex_cls    = cls_r;
      end else begin
        ex_status = ST_ALLOC;
        ex_addr   = ua_sum[ADDR_W-1:0];
        ex_cls    = cls_r;
        ex_we     = 1'b1;
        ex_waddr  = pop ? pop_g : bump32[GW+2:3];
        ex_wdata  = {{LW{1'b0}}, 1'b1, cls_r};
        head_we   = pop;
        head_wv   = rd_r[TW-1:TAG_LINK_LSB];
        bump_we   = !pop;
      end
    end else if (f_ok) begin
      ex_status = ST_FREED;
      ex_cls    = f_cls;
      ex_we     = 1'b1;
      ex_waddr  = gran_r;
      ex_wdata  = {head_rd, 1'b0, f_cls};
      head_we   = 1'b1;
      head_wi   = f_cls;
      head_wv   = LW'(gran_r) + LW'(1);
    end
  end

  // list head update
  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      head_nxt[c] = head_r[c];
    end
    if (cmd.fire && head_we) head_nxt[HIW'(head_wi)] = head_wv;
  end

  // tag write port: clearing pass or commit
  assign mem_we = cmd.clear || (cmd.fire && ex_we);
  assign waddr  = cmd.clear ? clr_cnt_r : ex_waddr;
  assign wdata  = cmd.clear ? TAG_RESET : ex_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[waddr] <= wdata;
  end

  assign sts.clear_last = (clr_cnt_r == GW'(GRANULES - 1));

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_r[c] <= '0;
      end
      bump_r    <= '0;
      limit_r   <= LIMIT_RESET;
      clr_cnt_r <= '0;
    end else begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_r[c] <= head_nxt[c];
      end
      if (cmd.fire && bump_we) bump_r <= bump_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + GW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      status_r     <= ex_status;
      user_addr_r  <= ex_addr;
      size_class_r <= ex_cls;
    end
  end

  assign out_status     = status_r;
  assign out_user_addr  = user_addr_r;
  assign out_size_class = size_class_r;

endmodule

// ----- sv/size_class_block_allocator_unit.sv -----
// Size-class block allocator. Each request (allocate or free) gives one result.
// A request is taken in the idle state, where the list head of its class and
// the tag memory are read, and finished in the execute state, where the tag
// is written, the list head or bump pointer is updated and the result register
// is loaded. The split between the two is set by the one read and one write
// port of the tag memory; the execute state stalls while an earlier result
// still waits for out_chan.ready. A new request is taken while a finished
// result still waits. After reset the tag memory is swept once, one granule a
// cycle; no request is taken during the sweep, while writes of the arena limit
// are taken at any time.
module size_class_block_allocator_unit #(
  parameter int unsigned ARENA_BYTES  = scba_pkg::DEF_ARENA_BYTES,
  parameter int unsigned HEADER_BYTES = scba_pkg::DEF_HEADER_BYTES,
  parameter int unsigned CLASS_COUNT  = scba_pkg::DEF_CLASS_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  scba_in_if.sink                       in_chan,
  scba_out_if.source                    out_chan,
  input  logic                          cfg_wr_en,
  input  logic [scba_pkg::LIMIT_W-1:0]  cfg_wr_data
);
  import scba_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  // sequencer
  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lists, tags and bump pointer
  scba_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .CLASS_COUNT  (CLASS_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_chan.action),
    .in_req_size    (in_chan.req_size),
    .in_free_addr   (in_chan.free_addr),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_status     (out_chan.status),
    .out_user_addr  (out_chan.user_addr),
    .out_size_class (out_chan.size_class)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

`ifndef SYNTHESIS
  // an accepted request is executed in the following cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> cmd.in_exec)
    else $error("accepted request not executed");

  // no request is taken during the tag sweep
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !in_chan.ready)
    else $error("request taken during tag sweep");

  // a new result appears only after an execute phase completed
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.fire))
    else $error("result without execute");

  // a freed block always reports a real class
  a_freed_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_FREED)) |->
      (32'(out_chan.size_class) < 32'(CLASS_COUNT)))
    else $error("freed block with bad class");
`endif

endmodule

// ----- tb/tb_size_class_block_allocator_unit.sv -----
`timescale 1ns / 100ps

module tb_size_class_block_allocator_unit;
  import scba_pkg::*;

  localparam int unsigned ARENA    = DEF_ARENA_BYTES;
  localparam int unsigned HDR      = DEF_HEADER_BYTES;
  localparam int unsigned CLASSES  = DEF_CLASS_COUNT;
  localparam int unsigned GRANULES = ARENA / 8;
  localparam int unsigned LINK_W   = 14;
  localparam int unsigned TAG_W    = TAG_LINK_LSB + LINK_W;

  typedef struct packed {
    logic              action;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_addr;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   user_addr;
    logic [CLS_W-1:0]    size_class;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [LIMIT_W-1:0]  cfg_wr_data;

  scba_in_if  in_chan ();
  scba_out_if out_chan ();

  size_class_block_allocator_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // allocator state as the testbench sees it
  logic [LIMIT_W-1:0] arena_limit;
  logic [16:0]        bump_ptr;
  logic [LINK_W-1:0]  list_head [CLASSES];
  logic [TAG_W-1:0]   block_tag [GRANULES];

  outcome_t          outcomes_due [$];
  outcome_t          last_outcome;
  logic [ADDR_W-1:0] live_addrs [$];
  logic [ADDR_W-1:0] freed_addrs [$];
  int                error_count = 0;
  int                send_gap_pct = 10;
  int                recv_stall_pct = 73;

  always #5 clk = ~clk;

  // outcome of one request, updates the allocator state
  function automatic outcome_t allocate_or_free(input request_t r);
    outcome_t         res;
    longint unsigned  total;
    longint unsigned  span;
    longint unsigned  ceiling;
    int               c;
    int unsigned      cls;
    int unsigned      blk;
    int unsigned      gran;
    logic [TAG_W-1:0] tag;
    logic             granted;
    res.status     = ST_IGNORED;
    res.user_addr  = '0;
    res.size_class = '0;
    granted        = 1'b0;
    if (r.action == ACT_ALLOC) begin
      total = r.req_size;
      total = total + HDR;
      cls   = CLASSES;
      for (c = CLASSES - 1; c >= 0; c--) begin
        if (total <= (64'd8 << c)) cls = c;
      end
      res.size_class = cls[CLS_W-1:0];
      res.status     = ST_NOSPACE;
      if (cls >= CLASSES) begin
        res.status = ST_LARGE;
      end else if (list_head[cls] != 0) begin
        // reuse the most recently freed block of this class
        gran = list_head[cls] - 1;
        blk  = gran * 8;
        if (blk + HDR <= USER_ADDR_MAX) begin
          list_head[cls] = block_tag[gran][TAG_W-1:TAG_LINK_LSB];
          granted = 1'b1;
        end
      end else begin
        // cut a fresh block from the bump pointer
        ceiling = (arena_limit < ARENA) ? arena_limit : ARENA;
        span    = 64'd8 << cls;
        blk     = bump_ptr;
        if (blk + span <= ceiling && blk + HDR <= USER_ADDR_MAX) begin
          gran     = blk / 8;
          bump_ptr = 17'(blk + span);
          granted  = 1'b1;
        end
      end
      if (granted) begin
        block_tag[gran] = {{LINK_W{1'b0}}, 1'b1, cls[CLS_W-1:0]};
        res.status      = ST_ALLOC;
        res.user_addr   = ADDR_W'(blk + HDR);
      end
    end else if (r.free_addr != 0 && r.free_addr >= HDR) begin
      blk = r.free_addr - HDR;
      if (blk % 8 == 0 && blk < ARENA) begin
        gran = blk / 8;
        tag  = block_tag[gran];
        cls  = tag[CLS_W-1:0];
        if (tag[TAG_LIVE_BIT] && cls < CLASSES) begin
          block_tag[gran] = {list_head[cls], 1'b0, tag[CLS_W-1:0]};
          list_head[cls]  = LINK_W'(gran + 1);
          res.status      = ST_FREED;
          res.size_class  = tag[CLS_W-1:0];
        end
      end
    end
    return res;
  endfunction

  function automatic request_t alloc_request(input logic [REQ_W-1:0] size);
    request_t r;
    r.action    = ACT_ALLOC;
    r.req_size  = size;
    r.free_addr = ADDR_W'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic request_t free_request(input logic [ADDR_W-1:0] addr);
    request_t r;
    r.action    = ACT_FREE;
    r.req_size  = $urandom;
    r.free_addr = addr;
    return r;
  endfunction

  // drive one request, predict its outcome once it is taken
  task automatic send_request(input request_t r);
    int i;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.action    <= r.action;
    in_chan.req_size  <= r.req_size;
    in_chan.free_addr <= r.free_addr;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    last_outcome = allocate_or_free(r);
    outcomes_due.push_back(last_outcome);
    // keep track of live and recently freed user addresses
    if (last_outcome.status == ST_ALLOC) begin
      live_addrs.push_back(last_outcome.user_addr);
    end else if (last_outcome.status == ST_FREED) begin
      for (i = 0; i < live_addrs.size(); i++) begin
        if (live_addrs[i] == r.free_addr) begin
          live_addrs.delete(i);
          break;
        end
      end
      freed_addrs.push_back(r.free_addr);
      if (freed_addrs.size() > 32) void'(freed_addrs.pop_front());
    end
  endtask

  // stop sending until every outcome has come back
  task automatic hold_until_drained();
    if (outcomes_due.size() != 0) begin
      in_chan.valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_arena_limit(input logic [LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    arena_limit = value;
  endtask

  // class edges and oversized requests
  task automatic test_class_boundaries();
    send_request(alloc_request(0));
    send_request(alloc_request(1));
    send_request(alloc_request(8));
    send_request(alloc_request(9));
    send_request(alloc_request(4088));
    send_request(alloc_request(4089));
    send_request(alloc_request(32'hFFFF_FFFF));
    send_request(alloc_request(32'h8000_0000));
  endtask

  // frees that must be ignored, double free, lifo reuse
  task automatic test_free_filtering();
    send_request(free_request(16'h0000));
    send_request(free_request(16'h0007));
    send_request(free_request(16'h000D));
    send_request(free_request(16'hFFFF));
    send_request(free_request(16'h8008));
    send_request(free_request(16'h0008));
    send_request(free_request(16'h0008));
    send_request(alloc_request(0));
    send_request(free_request(16'h0010));
    send_request(free_request(16'h0020));
    send_request(alloc_request(1));
    send_request(alloc_request(1));
  endtask

  // zero limit blocks the bump pointer, limit above arena is clipped
  task automatic test_limit_extremes();
    hold_until_drained();
    write_arena_limit('0);
    send_request(alloc_request(0));
    send_request(alloc_request(100));
    hold_until_drained();
    write_arena_limit({LIMIT_W{1'b1}});
    send_request(alloc_request(20));
  endtask

  // mostly alloc and free of live blocks, with stale and junk frees
  task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct,
                                     input logic [LIMIT_W-1:0] limit);
    int          sent;
    int          pick;
    int unsigned cls;
    int unsigned lo;
    int unsigned hi;
    request_t    r;
    hold_until_drained();
    write_arena_limit(limit);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (sent = 0; sent < count; sent++) begin
      pick = $urandom_range(0, 99);
      if (live_addrs.size() != 0 && (pick < 40 || (live_addrs.size() > 48 && pick < 70))) begin
        r = free_request(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else if (pick < 85) begin
        cls = ($urandom_range(0, 3) == 0) ? $urandom_range(6, CLASSES - 1)
                                          : $urandom_range(0, 5);
        hi  = (8 << cls) - HDR;
        lo  = (cls == 0) ? 0 : (4 << cls) - HDR + 1;
        r   = alloc_request($urandom_range(lo, hi));
      end else if (pick < 90) begin
        r = alloc_request($urandom_range(0, 1) ? $urandom : $urandom_range(4089, 8191));
      end else if (pick < 95 && freed_addrs.size() != 0) begin
        r = free_request(freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
      end else begin
        r = free_request(ADDR_W'($urandom_range(0, 65535)));
      end
      send_request(r);
      if ($urandom_range(0, 199) == 0) hold_until_drained();
    end
  endtask

  // allocate in every class, largest first, until space runs out or 400 tries
  task automatic test_arena_exhaustion();
    int cls;
    int tries;
    hold_until_drained();
    for (cls = CLASSES - 1; cls >= 0; cls--) begin
      tries = 0;
      do begin
        send_request(alloc_request((8 << cls) - HDR));
        tries++;
      end while (last_outcome.status == ST_ALLOC && tries < 400);
    end
  endtask

  // result side: random stalls and in-order comparison
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (outcomes_due.size() == 0) begin
          $error("unexpected result: status %0d, user_addr %0d, size_class %0d",
                 out_chan.status, out_chan.user_addr, out_chan.size_class);
          error_count++;
        end else begin
          if (out_chan.status !== outcomes_due[0].status) begin
            $error("status: expected %0d, actual %0d",
                   outcomes_due[0].status, out_chan.status);
            error_count++;
          end
          if (out_chan.user_addr !== outcomes_due[0].user_addr) begin
            $error("user_addr: expected %0d, actual %0d",
                   outcomes_due[0].user_addr, out_chan.user_addr);
            error_count++;
          end
          if (out_chan.size_class !== outcomes_due[0].size_class) begin
            $error("size_class: expected %0d, actual %0d",
                   outcomes_due[0].size_class, out_chan.size_class);
            error_count++;
          end
          void'(outcomes_due.pop_front());
        end
      end
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int i;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_chan.valid      = 1'b0;
    in_chan.action     = ACT_ALLOC;
    in_chan.req_size   = '0;
    in_chan.free_addr  = '0;
    // state after reset
    arena_limit = LIMIT_RESET;
    bump_ptr    = '0;
    for (i = 0; i < CLASSES; i++) list_head[i] = '0;
    for (i = 0; i < GRANULES; i++) block_tag[i] = {{LINK_W{1'b0}}, 1'b0, TAG_CLASS_NONE};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_class_boundaries();
    test_free_filtering();
    test_limit_extremes();
    test_random_traffic(400, 10, 73, {LIMIT_W{1'b1}});
    test_random_traffic(400, 73, 10, LIMIT_W'($urandom_range(32768, 65535)));
    test_random_traffic(400, 0, 0, LIMIT_RESET);
    test_arena_exhaustion();

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- size_class_block_allocator_unit.f -----
sv/scba_pkg.sv
sv/scba_if.sv
sv/scba_ctrl.sv
sv/scba_datapath.sv
sv/size_class_block_allocator_unit.sv
tb/tb_size_class_block_allocator_unit.sv
